### rtl/core/assert_macros.svh
// Assertion macros shared by the vertex rotator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AVR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vertex rotator assertion failed");

`define AVR_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vertex rotator assertion failed");

`else

`define AVR_ASSERT(label, clk, rst_n, prop)

`define AVR_ASSERT_NR(label, clk, prop)

`endif

`endif

### rtl/core/avr_pkg.sv
// Types, constants and the quarter-wave sine table of the vertex rotator.
package avr_pkg;

  localparam int ANGLE_BITS  = 12;
  localparam int COORD_BITS  = 32;
  localparam int CFG_W       = 12;
  localparam int AXIS_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int QSHIFT      = ANGLE_BITS - 2;
  localparam int QUARTER     = 1 << QSHIFT;
  localparam int TRIG_W      = 18;
  localparam int FRAC_BITS   = 16;
  localparam int DIGIT_BITS  = 16;
  localparam int NDIG        = (COORD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DIG_W       = NDIG * DIGIT_BITS;
  localparam int PROD_W      = TRIG_W + DIGIT_BITS + 1;
  localparam int ACC_W       = COORD_BITS + 19;
  localparam int RND_W       = ACC_W - FRAC_BITS;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef logic        [CFG_W-1:0]        cfg_word_t;
  typedef logic        [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic        [AXIS_W-1:0]       axis_t;
  typedef logic        [ANGLE_BITS-1:0]   angle_t;
  typedef logic        [QSHIFT:0]         rom_addr_t;
  typedef logic        [TRIG_W-2:0]       rom_word_t;
  typedef logic signed [TRIG_W-1:0]       trig_t;
  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [DIG_W-1:0]        dig_t;
  typedef logic signed [DIGIT_BITS:0]     digit_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef logic signed [RND_W-1:0]        rnd_t;

  localparam cfg_idx_t REG_ANGLE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_AXIS  = cfg_idx_t'(1);

  localparam axis_t AXIS_X = axis_t'(0);
  localparam axis_t AXIS_Y = axis_t'(1);
  localparam axis_t AXIS_Z = axis_t'(2);

  localparam rom_addr_t QUARTER_ADDR = rom_addr_t'(QUARTER);
  localparam acc_t      ROUND_HALF   = acc_t'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
    logic   last_vertex;
  } in_beat_t;

  typedef struct packed {
    coord_t rot_x;
    coord_t rot_y;
    coord_t rot_z;
    logic   last_out;
  } out_beat_t;

  // Lane a is cos*p + sin_n*q, lane b is sin_p*p + cos*q.
  typedef struct packed {
    trig_t cos;
    trig_t sin_p;
    trig_t sin_n;
  } coef_t;

  typedef struct packed {
    axis_t axis;
    coef_t coef;
  } rot_cfg_t;

  typedef struct packed {
    acc_t   acc_a;
    acc_t   acc_b;
    dig_t   op_p;
    dig_t   op_q;
    logic   msd;
    coord_t thru;
    logic   last;
  } cell_t;

  typedef rom_word_t sine_rom_t [QUARTER+1];

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return full[125:62];
  endfunction

  // Shift-and-subtract quotient, used only while the constant table is built.
  function automatic logic [63:0] quot_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rem_mask;
    logic [63:0] den;
    rem_mask = (64'd1 << QSHIFT) - 64'd1;
    for (int k = 0; k <= QUARTER; k++) begin
      x = (HALF_PI_Q62 >> QSHIFT) * 64'(k)
        + (((HALF_PI_Q62 & rem_mask) * 64'(k)) >> QSHIFT);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n < 24 && term != 64'd0; n++) begin
        den  = 64'(2 * n) * 64'(2 * n + 1);
        term = quot_u64(mul_q62(term, x2), den);
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      rom[k] = rom_word_t'((sum + (64'd1 << 45)) >> 46);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### rtl/core/avr_trig.sv
// Configuration registers and the sine and cosine coefficients of the rotation.
module avr_trig (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  avr_pkg::cfg_idx_t   cfg_index,
  input  avr_pkg::cfg_word_t  cfg_data,
  output avr_pkg::rot_cfg_t   rot_cfg
);

  avr_pkg::rom_word_t lo_r;
  avr_pkg::rom_word_t hi_r;
  logic [1:0]         quad_r;
  avr_pkg::axis_t     axis_r;

  avr_pkg::angle_t    angle_wr;
  avr_pkg::rom_addr_t addr_lo;
  avr_pkg::rom_addr_t addr_hi;
  avr_pkg::trig_t     lo_s;
  avr_pkg::trig_t     hi_s;
  avr_pkg::trig_t     sn;
  avr_pkg::trig_t     cs;
  avr_pkg::trig_t     sp;

  assign angle_wr = avr_pkg::angle_t'(cfg_data);
  assign addr_lo  = avr_pkg::rom_addr_t'(angle_wr[avr_pkg::QSHIFT-1:0]);
  assign addr_hi  = avr_pkg::QUARTER_ADDR - addr_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= avr_pkg::SINE_ROM[0];
      hi_r   <= avr_pkg::SINE_ROM[avr_pkg::QUARTER];
      quad_r <= 2'b00;
      axis_r <= avr_pkg::AXIS_Z;
    end else if (cfg_wr_en) begin
      if (cfg_index == avr_pkg::REG_ANGLE) begin
        lo_r   <= avr_pkg::SINE_ROM[addr_lo];
        hi_r   <= avr_pkg::SINE_ROM[addr_hi];
        quad_r <= angle_wr[avr_pkg::ANGLE_BITS-1 -: 2];
      end
      if (cfg_index == avr_pkg::REG_AXIS) begin
        axis_r <= avr_pkg::axis_t'(cfg_data[avr_pkg::AXIS_W-1:0]);
      end
    end
  end

  // Odd quadrants swap the table reads; the sign follows the quadrant.
  always_comb begin
    lo_s = avr_pkg::trig_t'(lo_r);
    hi_s = avr_pkg::trig_t'(hi_r);
    sn   = quad_r[0] ? hi_s : lo_s;
    cs   = quad_r[0] ? lo_s : hi_s;
    if (quad_r[1]) begin
      sn = -sn;
    end
    if (quad_r[1] ^ quad_r[0]) begin
      cs = -cs;
    end
    sp = (axis_r == avr_pkg::AXIS_Y) ? -sn : sn;
    rot_cfg.axis       = axis_r;
    rot_cfg.coef.cos   = cs;
    rot_cfg.coef.sin_p = sp;
    rot_cfg.coef.sin_n = -sp;
  end

endmodule

### rtl/core/avr_cell.sv
// One digit cell: multiply-accumulates a 16-bit digit of both operands into two lanes.
module avr_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  avr_pkg::coef_t  coef,
  input  logic            up_vld,
  input  avr_pkg::cell_t  up_dat,
  output logic            up_rdy,
  output logic            dn_vld,
  output avr_pkg::cell_t  dn_dat,
  input  logic            dn_rdy
);

  logic             vld_r;
  avr_pkg::cell_t   dat_r;
  avr_pkg::cell_t   dat_nxt;
  avr_pkg::digit_t  dig_p;
  avr_pkg::digit_t  dig_q;
  avr_pkg::prod_t   pa_p;
  avr_pkg::prod_t   pa_q;
  avr_pkg::prod_t   pb_p;
  avr_pkg::prod_t   pb_q;

  assign up_rdy = !vld_r || dn_rdy;
  assign dn_vld = vld_r;
  assign dn_dat = dat_r;

  // The most significant digit carries the sign; the others are unsigned.
  always_comb begin
    if (up_dat.msd) begin
      dig_p = avr_pkg::digit_t'($signed(up_dat.op_p[avr_pkg::DIG_W-1 -: avr_pkg::DIGIT_BITS]));
      dig_q = avr_pkg::digit_t'($signed(up_dat.op_q[avr_pkg::DIG_W-1 -: avr_pkg::DIGIT_BITS]));
    end else begin
      dig_p = avr_pkg::digit_t'(up_dat.op_p[avr_pkg::DIG_W-1 -: avr_pkg::DIGIT_BITS]);
      dig_q = avr_pkg::digit_t'(up_dat.op_q[avr_pkg::DIG_W-1 -: avr_pkg::DIGIT_BITS]);
    end
    pa_p = avr_pkg::prod_t'(coef.cos)   * avr_pkg::prod_t'(dig_p);
    pa_q = avr_pkg::prod_t'(coef.sin_n) * avr_pkg::prod_t'(dig_q);
    pb_p = avr_pkg::prod_t'(coef.sin_p) * avr_pkg::prod_t'(dig_p);
    pb_q = avr_pkg::prod_t'(coef.cos)   * avr_pkg::prod_t'(dig_q);
    dat_nxt       = up_dat;
    dat_nxt.acc_a = (up_dat.acc_a <<< avr_pkg::DIGIT_BITS)
                  + avr_pkg::acc_t'(pa_p) + avr_pkg::acc_t'(pa_q);
    dat_nxt.acc_b = (up_dat.acc_b <<< avr_pkg::DIGIT_BITS)
                  + avr_pkg::acc_t'(pb_p) + avr_pkg::acc_t'(pb_q);
    dat_nxt.op_p  = up_dat.op_p << avr_pkg::DIGIT_BITS;
    dat_nxt.op_q  = up_dat.op_q << avr_pkg::DIGIT_BITS;
    dat_nxt.msd   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

### rtl/core/axis_vertex_rotator_core.sv
// Top level of the vertex rotator: operand selection, digit cell chain and output register.
// Rotates each vertex beat about the configured axis and delivers one beat per vertex,
// in order. A new vertex is taken in every cycle while out_stall does not back up the
// chain. Each vertex passes through the chain of digit cells, each of which folds one
// 16-bit digit of both rotated coordinates into its accumulators, followed
// by the rounding and saturating output register. Writing the angle reads sine and
// cosine from the quarter-wave table at once, so a beat offered after the write is
// rotated by the new angle. Write the registers only while no beat is in flight.
`include "assert_macros.svh"

module axis_vertex_rotator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  avr_pkg::cfg_idx_t   cfg_index,
  input  avr_pkg::cfg_word_t  cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  avr_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output avr_pkg::out_beat_t  out_data
);

  avr_pkg::rot_cfg_t   rot_cfg;
  logic [avr_pkg::NDIG:0] link_vld;
  logic [avr_pkg::NDIG:0] link_rdy;
  avr_pkg::cell_t      link_dat [avr_pkg::NDIG+1];

  logic                out_vld_r;
  avr_pkg::out_beat_t  out_dat_r;
  avr_pkg::out_beat_t  out_nxt;
  logic                out_rdy;
  avr_pkg::coord_t     res_a;
  avr_pkg::coord_t     res_b;

  function automatic avr_pkg::coord_t round_sat(input avr_pkg::acc_t acc);
    avr_pkg::acc_t biased;
    avr_pkg::rnd_t r;
    biased = acc + avr_pkg::ROUND_HALF;
    r      = avr_pkg::rnd_t'(biased >>> avr_pkg::FRAC_BITS);
    if ((&r[avr_pkg::RND_W-1:avr_pkg::COORD_BITS-1]) ||
        !(|r[avr_pkg::RND_W-1:avr_pkg::COORD_BITS-1])) begin
      return avr_pkg::coord_t'(r);
    end else if (r[avr_pkg::RND_W-1]) begin
      return {1'b1, {(avr_pkg::COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(avr_pkg::COORD_BITS-1){1'b1}}};
    end
  endfunction

  avr_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rot_cfg   (rot_cfg)
  );

  // The coordinate on the rotation axis travels through untouched.
  always_comb begin
    link_dat[0]       = '0;
    link_dat[0].msd   = 1'b1;
    link_dat[0].last  = in_data.last_vertex;
    case (rot_cfg.axis)
      avr_pkg::AXIS_X: begin
        link_dat[0].op_p = avr_pkg::dig_t'(in_data.coord_y);
        link_dat[0].op_q = avr_pkg::dig_t'(in_data.coord_z);
        link_dat[0].thru = in_data.coord_x;
      end
      avr_pkg::AXIS_Y: begin
        link_dat[0].op_p = avr_pkg::dig_t'(in_data.coord_x);
        link_dat[0].op_q = avr_pkg::dig_t'(in_data.coord_z);
        link_dat[0].thru = in_data.coord_y;
      end
      default: begin
        link_dat[0].op_p = avr_pkg::dig_t'(in_data.coord_x);
        link_dat[0].op_q = avr_pkg::dig_t'(in_data.coord_y);
        link_dat[0].thru = in_data.coord_z;
      end
    endcase
  end

  assign link_vld[0] = in_valid;
  assign in_stall    = !link_rdy[0];

  for (genvar g = 0; g < avr_pkg::NDIG; g++) begin : g_cell
    avr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .coef   (rot_cfg.coef),
      .up_vld (link_vld[g]),
      .up_dat (link_dat[g]),
      .up_rdy (link_rdy[g]),
      .dn_vld (link_vld[g+1]),
      .dn_dat (link_dat[g+1]),
      .dn_rdy (link_rdy[g+1])
    );
  end

  assign out_rdy                = !out_vld_r || !out_stall;
  assign link_rdy[avr_pkg::NDIG] = out_rdy;

  always_comb begin
    res_a            = round_sat(link_dat[avr_pkg::NDIG].acc_a);
    res_b            = round_sat(link_dat[avr_pkg::NDIG].acc_b);
    out_nxt.last_out = link_dat[avr_pkg::NDIG].last;
    case (rot_cfg.axis)
      avr_pkg::AXIS_X: begin
        out_nxt.rot_x = link_dat[avr_pkg::NDIG].thru;
        out_nxt.rot_y = res_a;
        out_nxt.rot_z = res_b;
      end
      avr_pkg::AXIS_Y: begin
        out_nxt.rot_x = res_a;
        out_nxt.rot_y = link_dat[avr_pkg::NDIG].thru;
        out_nxt.rot_z = res_b;
      end
      default: begin
        out_nxt.rot_x = res_a;
        out_nxt.rot_y = res_b;
        out_nxt.rot_z = link_dat[avr_pkg::NDIG].thru;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= link_vld[avr_pkg::NDIG];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && link_vld[avr_pkg::NDIG]) begin
      out_dat_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_dat_r;

  `AVR_ASSERT(a_accept_fills_first_cell, clk, rst_n, link_vld[0] && link_rdy[0] |=> link_vld[1])
  `AVR_ASSERT(a_stall_only_when_full, clk, rst_n, in_stall |-> out_valid && (&link_vld[avr_pkg::NDIG:1]))
  `AVR_ASSERT(a_last_cell_holds, clk, rst_n, link_vld[avr_pkg::NDIG] && !link_rdy[avr_pkg::NDIG] |=> link_vld[avr_pkg::NDIG])
  `AVR_ASSERT_NR(a_reset_empties_output, clk, !rst_n |=> !out_valid)

endmodule

### verif/avr_rotation_checker.sv
// Checker for the vertex rotator: predicts each rotated vertex and compares it with the output beats.
`timescale 1ns / 100ps

module avr_rotation_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  avr_pkg::cfg_idx_t  cfg_index,
  input  avr_pkg::cfg_word_t cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  avr_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  avr_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 pending
);

  localparam longint unsigned PI_HALF_Q62 = 64'h6487ED5110B4611A;
  localparam longint          COORD_MAX   = (longint'(1) <<< (avr_pkg::COORD_BITS - 1)) - 1;
  localparam longint          COORD_MIN   = -COORD_MAX - 1;
  localparam int              REPORT_MAX  = 10;

  longint             sine_quarter [0:avr_pkg::QUARTER];
  avr_pkg::angle_t    angle_reg = '0;
  avr_pkg::axis_t     axis_reg  = avr_pkg::AXIS_Z;
  avr_pkg::out_beat_t expected_vertices [$];
  int                 mismatches = 0;

  function automatic longint unsigned q62_product(longint unsigned a, longint unsigned b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return full[125:62];
  endfunction

  // Taylor series of sine on the first quarter turn, evaluated in unsigned Q2.62.
  initial begin : fill_sine
    longint unsigned rem_mask;
    longint unsigned phase;
    longint unsigned phase_sq;
    longint unsigned term;
    longint unsigned series;
    rem_mask = (64'd1 << avr_pkg::QSHIFT) - 64'd1;
    for (int k = 0; k <= avr_pkg::QUARTER; k++) begin
      phase = (PI_HALF_Q62 >> avr_pkg::QSHIFT) * longint'(k)
            + (((PI_HALF_Q62 & rem_mask) * longint'(k)) >> avr_pkg::QSHIFT);
      phase_sq = q62_product(phase, phase);
      term     = phase;
      series   = phase;
      for (int n = 1; n < 24 && term != 0; n++) begin
        term = q62_product(term, phase_sq) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          series = series - term;
        end else begin
          series = series + term;
        end
      end
      sine_quarter[k] = longint'((series + (64'd1 << 45)) >> 46);
    end
  end

  function automatic avr_pkg::coord_t round_sat(longint c, longint p, longint s, longint q);
    longint sum;
    sum = (c * p + s * q + longint'(32768)) >>> avr_pkg::FRAC_BITS;
    if (sum > COORD_MAX) begin
      sum = COORD_MAX;
    end else if (sum < COORD_MIN) begin
      sum = COORD_MIN;
    end
    return avr_pkg::coord_t'(sum);
  endfunction

  function automatic avr_pkg::out_beat_t rotate_vertex(avr_pkg::in_beat_t v);
    avr_pkg::out_beat_t r;
    longint     sn;
    longint     cs;
    longint     x;
    longint     y;
    longint     z;
    logic [1:0] quad;
    int         idx;
    quad = angle_reg[avr_pkg::ANGLE_BITS-1 -: 2];
    idx  = int'(angle_reg[avr_pkg::QSHIFT-1:0]);
    case (quad)
      2'd0: begin
        sn = sine_quarter[idx];
        cs = sine_quarter[avr_pkg::QUARTER - idx];
      end
      2'd1: begin
        sn = sine_quarter[avr_pkg::QUARTER - idx];
        cs = -sine_quarter[idx];
      end
      2'd2: begin
        sn = -sine_quarter[idx];
        cs = -sine_quarter[avr_pkg::QUARTER - idx];
      end
      default: begin
        sn = -sine_quarter[avr_pkg::QUARTER - idx];
        cs = sine_quarter[idx];
      end
    endcase
    x = longint'($signed(v.coord_x));
    y = longint'($signed(v.coord_y));
    z = longint'($signed(v.coord_z));
    r.rot_x    = v.coord_x;
    r.rot_y    = v.coord_y;
    r.rot_z    = v.coord_z;
    r.last_out = v.last_vertex;
    if (axis_reg == avr_pkg::AXIS_X) begin
      r.rot_y = round_sat(cs, y, -sn, z);
      r.rot_z = round_sat(sn, y, cs, z);
    end else if (axis_reg == avr_pkg::AXIS_Y) begin
      r.rot_x = round_sat(cs, x, sn, z);
      r.rot_z = round_sat(-sn, x, cs, z);
    end else begin
      r.rot_x = round_sat(cs, x, -sn, y);
      r.rot_y = round_sat(sn, x, cs, y);
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    avr_pkg::out_beat_t want;
    if (!rst_n) begin
      angle_reg = '0;
      axis_reg  = avr_pkg::AXIS_Z;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == avr_pkg::REG_ANGLE) begin
          angle_reg = avr_pkg::angle_t'(cfg_data);
        end else if (cfg_index == avr_pkg::REG_AXIS) begin
          axis_reg = cfg_data[avr_pkg::AXIS_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        expected_vertices.push_back(rotate_vertex(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("unexpected output beat: x=%h y=%h z=%h last=%b",
                     out_data.rot_x, out_data.rot_y, out_data.rot_z, out_data.last_out);
          end
        end else begin
          want = expected_vertices.pop_front();
          if (out_data.rot_x !== want.rot_x || out_data.rot_y !== want.rot_y ||
              out_data.rot_z !== want.rot_z || out_data.last_out !== want.last_out) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display({"vertex mismatch: expected x=%h y=%h z=%h last=%b, ",
                        "got x=%h y=%h z=%h last=%b"},
                       want.rot_x, want.rot_y, want.rot_z, want.last_out,
                       out_data.rot_x, out_data.rot_y, out_data.rot_z, out_data.last_out);
            end
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_vertices.size();
  end

endmodule

### verif/tb_top.sv
// Testbench top for the vertex rotator: clock, reset, register writes, vertex stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_ITEMS    = 125;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_wr_en = 1'b0;
  avr_pkg::cfg_idx_t  cfg_index = avr_pkg::REG_ANGLE;
  avr_pkg::cfg_word_t cfg_data  = '0;
  logic               in_valid  = 1'b0;
  avr_pkg::in_beat_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  avr_pkg::out_beat_t out_data;
  int                 fail_count;
  int                 pending;
  int                 quiet_cycles = 0;
  int                 gap_mode     = 0;

  axis_vertex_rotator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  avr_rotation_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("axis_vertex_rotator_core regression: fail");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic avr_pkg::coord_t pick_coord();
    avr_pkg::coord_t cmax;
    cmax = {1'b0, {(avr_pkg::COORD_BITS-1){1'b1}}};
    case ($urandom_range(0, 11))
      0:       return cmax;
      1:       return ~cmax;
      2:       return '0;
      3:       return avr_pkg::coord_t'($urandom_range(0, 262143)) - avr_pkg::coord_t'(131072);
      4:       return cmax - avr_pkg::coord_t'($urandom_range(0, 65535));
      5:       return ~cmax + avr_pkg::coord_t'($urandom_range(0, 65535));
      default: return avr_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic avr_pkg::in_beat_t make_vertex(avr_pkg::coord_t x, avr_pkg::coord_t y,
                                                    avr_pkg::coord_t z, logic last);
    avr_pkg::in_beat_t b;
    b.coord_x     = x;
    b.coord_y     = y;
    b.coord_z     = z;
    b.last_vertex = last;
    return b;
  endfunction

  // The receiver alternates short free runs, occasional long free runs and random stalls.
  initial begin : stall_gen
    int n;
    @(posedge clk);
    forever begin
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 4))
        @(posedge clk);
      n = idle_len();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic write_reg(avr_pkg::cfg_idx_t idx, avr_pkg::cfg_word_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rotation(avr_pkg::angle_t angle, avr_pkg::axis_t axis);
    avr_pkg::cfg_word_t upper;
    upper = avr_pkg::cfg_word_t'($urandom);
    write_reg(avr_pkg::REG_ANGLE, avr_pkg::cfg_word_t'(angle));
    write_reg(avr_pkg::REG_AXIS, {upper[avr_pkg::CFG_W-1:avr_pkg::AXIS_W], axis});
  endtask

  task automatic send_vertex(avr_pkg::in_beat_t beat);
    int gap;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = (gap_mode != 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    avr_pkg::coord_t cmax;
    avr_pkg::coord_t cmin;
    avr_pkg::coord_t half;
    avr_pkg::angle_t angle;
    avr_pkg::axis_t  axis;
    cmax = {1'b0, {(avr_pkg::COORD_BITS-1){1'b1}}};
    cmin = ~cmax;
    half = avr_pkg::coord_t'(32'h0000_8000);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values give the identity rotation about z.
    send_vertex(make_vertex(cmax, cmin, avr_pkg::coord_t'($urandom), 1'b1));
    send_vertex(make_vertex(cmin, cmax, half, 1'b0));
    wait_idle();

    // At an eighth of a turn the half coordinate lands exactly on a rounding tie,
    // and the extremes saturate.
    for (int a = 0; a < 4; a++) begin
      set_rotation(avr_pkg::angle_t'(avr_pkg::QUARTER / 2), avr_pkg::axis_t'(a));
      send_vertex(make_vertex(cmax, cmax, cmax, 1'b1));
      send_vertex(make_vertex(cmin, cmin, cmin, 1'b0));
      send_vertex(make_vertex(cmax, cmin, '0, 1'b1));
      send_vertex(make_vertex(half, '0, half, 1'b0));
      send_vertex(make_vertex(-half, half, -avr_pkg::coord_t'(1), 1'b1));
      wait_idle();
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       angle = '0;
        1:       angle = '1;
        2:       angle = avr_pkg::angle_t'(avr_pkg::QUARTER);
        3:       angle = avr_pkg::angle_t'(2 * avr_pkg::QUARTER);
        4:       angle = avr_pkg::angle_t'(3 * avr_pkg::QUARTER);
        5:       angle = avr_pkg::angle_t'(1);
        6:       angle = avr_pkg::angle_t'(2 * avr_pkg::QUARTER - 1);
        default: angle = avr_pkg::angle_t'($urandom);
      endcase
      axis     = (ph < 8) ? avr_pkg::axis_t'(ph) : avr_pkg::axis_t'($urandom);
      gap_mode = (ph % 3 != 2) ? 1 : 0;
      set_rotation(angle, axis);
      repeat (PHASE_ITEMS) begin
        send_vertex(make_vertex(pick_coord(), pick_coord(), pick_coord(),
                                $urandom_range(0, 7) == 0));
      end
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("axis_vertex_rotator_core regression: pass");
    end else begin
      $display("axis_vertex_rotator_core regression: fail");
    end
    $finish;
  end

endmodule
